/* sv/gmf_pkg.sv */
// Shared types and constants for the grid majority filter.
package gmf_pkg;

  localparam int MAX_SIDE_DEFAULT = 32;
  localparam int GRID_SIDE_W      = 6;
  localparam int GRID_SIDE_RST    = 32;
  localparam int FIFO_DEPTH       = 8;

  typedef struct packed {
    logic top;
    logic mid;
    logic bot;
  } col_t;

  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
  } vote_mask_t;

  typedef struct packed {
    logic next_ill;
    logic frame_end;
  } result_t;

endpackage

/* sv/gmf_line_store.sv */
// One row store: single write port, registered read with write-through.
module gmf_line_store #(
  parameter int Depth = gmf_pkg::MAX_SIDE_DEFAULT,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic mem_q [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/gmf_col_cell.sv */
// Window cell: holds one three-row column and hands it to its neighbor.
module gmf_col_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         shift_i,
  input  gmf_pkg::col_t col_i,
  output gmf_pkg::col_t col_o
);

  gmf_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

/* sv/gmf_vote.sv */
// Majority vote over the in-grid neighbors of one cell.
module gmf_vote (
  input  gmf_pkg::col_t      left_i,
  input  gmf_pkg::col_t      center_i,
  input  gmf_pkg::col_t      right_i,
  input  gmf_pkg::vote_mask_t mask_i,
  output logic               ill_o
);

  logic [7:0] val;
  logic [7:0] msk;
  logic [3:0] ills;
  logic [3:0] heals;

  always_comb begin
    val = {left_i.top, left_i.mid, left_i.bot,
           center_i.top, center_i.bot,
           right_i.top, right_i.mid, right_i.bot};
    msk = {mask_i.left_ok & mask_i.top_ok, mask_i.left_ok, mask_i.left_ok & mask_i.bot_ok,
           mask_i.top_ok, mask_i.bot_ok,
           mask_i.right_ok & mask_i.top_ok, mask_i.right_ok,
           mask_i.right_ok & mask_i.bot_ok};
    ills  = '0;
    heals = '0;
    for (int i = 0; i < 8; i++) begin
      ills  = ills + 4'(val[i] & msk[i]);
      heals = heals + 4'(~val[i] & msk[i]);
    end
    priority if (heals > ills) begin
      ill_o = 1'b0;
    end else if (ills > heals) begin
      ill_o = 1'b1;
    end else begin
      ill_o = center_i.mid;
    end
  end

endmodule

/* sv/grid_majority_filter_core.sv */
// Top level: 3x3 binary majority filter over a raster-streamed square grid.
// A beat is registered in s1, then in the window and s2; the result it completes is queued;
// last-row results are formed in the side flush slots that follow the final beat of a frame.
// Throughput: one input beat per clock when not stalled; up to two results at each row end.
// After a frame's last beat, input stalls while the last row drains.
// Reset clears counters, window and queue, sets side to min(32, MaxSide), not the row stores.
module grid_majority_filter_core #(
  parameter int MaxSide = gmf_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gmf_pkg::GRID_SIDE_W-1:0] cfg_grid_side_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cell_ill_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            next_ill_o,
  output logic                            frame_end_o
);

  localparam int SideW   = $clog2(MaxSide + 1);
  localparam int AddrW   = $clog2(MaxSide);
  localparam int SideRst = (gmf_pkg::GRID_SIDE_RST > MaxSide) ? MaxSide
                                                             : gmf_pkg::GRID_SIDE_RST;
  localparam int PtrW    = $clog2(gmf_pkg::FIFO_DEPTH);
  localparam int CntW    = $clog2(gmf_pkg::FIFO_DEPTH + 1);

  logic [SideW-1:0] side_q, side_d, side_m1;
  logic [SideW-1:0] row_q;
  logic [AddrW-1:0] col_q;
  logic             flushing, credit_ok, slot_go, at_last_col, cfg_we;
  logic [CntW:0]    need;

  logic             s1_v_q, s1_bit_q;
  logic [SideW-1:0] s1_row_q;
  logic [AddrW-1:0] s1_col_q;
  logic             s2_v_q;
  logic [SideW-1:0] s2_row_q;
  logic [AddrW-1:0] s2_col_q;

  logic             top_rd, mid_rd, store_we;
  gmf_pkg::col_t    new_col;
  gmf_pkg::col_t    win [3];

  gmf_pkg::vote_mask_t mask_p, mask_s;
  logic             ill_p, ill_s, emit_p, emit_s, top_ok, bot_ok;
  gmf_pkg::result_t res_p, res_s, first_res;
  logic [1:0]       n_push;
  logic             pop;

  gmf_pkg::result_t fifo_q [gmf_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]  head_q, tail_q;
  logic [CntW-1:0]  count_q;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    priority if (cfg_grid_side_i == '0) begin
      side_d = SideW'(1);
    end else if (int'(cfg_grid_side_i) > MaxSide) begin
      side_d = SideW'(MaxSide);
    end else begin
      side_d = SideW'(cfg_grid_side_i);
    end
  end

  // slot sequencer
  assign side_m1     = side_q - 1'b1;
  assign flushing    = (row_q == side_q);
  assign at_last_col = (SideW'(col_q) == side_m1);
  assign need        = (CntW+1)'(count_q) + (CntW+1)'({s1_v_q, 1'b0})
                     + (CntW+1)'({s2_v_q, 1'b0}) + (CntW+1)'(2);
  assign credit_ok   = (need <= (CntW+1)'(gmf_pkg::FIFO_DEPTH));
  assign slot_go     = credit_ok & (flushing | in_valid_i);
  assign in_stall_o  = flushing | ~credit_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideW'(SideRst);
      row_q  <= '0;
      col_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= slot_go & ~cfg_we;
      s2_v_q <= s1_v_q & ~cfg_we;
      if (cfg_we) begin
        side_q <= side_d;
        row_q  <= '0;
        col_q  <= '0;
      end else if (slot_go) begin
        if (at_last_col) begin
          col_q <= '0;
          row_q <= flushing ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_go) begin
      s1_row_q <= row_q;
      s1_col_q <= col_q;
      s1_bit_q <= flushing ? 1'b0 : cell_ill_i;
    end
    if (s1_v_q) begin
      s2_row_q <= s1_row_q;
      s2_col_q <= s1_col_q;
    end
  end

  // row stores
  assign store_we = s1_v_q & (s1_row_q != side_q);

  gmf_line_store #(.Depth(MaxSide), .AddrW(AddrW)) u_top_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .raddr_i (col_q),
    .rdata_o (top_rd)
  );

  gmf_line_store #(.Depth(MaxSide), .AddrW(AddrW)) u_mid_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_col_q),
    .wdata_i (s1_bit_q),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // window chain, newest column in cell 2
  assign new_col = '{top: top_rd, mid: mid_rd, bot: s1_bit_q};

  gmf_col_cell u_cell2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(s1_v_q), .col_i(new_col), .col_o(win[2])
  );
  gmf_col_cell u_cell1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(s1_v_q), .col_i(win[2]), .col_o(win[1])
  );
  gmf_col_cell u_cell0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(s1_v_q), .col_i(win[1]), .col_o(win[0])
  );

  // votes: primary centered one column back, secondary on the row's last column
  assign top_ok = (s2_row_q > SideW'(1));
  assign bot_ok = (s2_row_q < side_q);
  assign emit_p = s2_v_q & (s2_row_q != '0) & (s2_col_q != '0);
  assign emit_s = s2_v_q & (s2_row_q != '0) & (SideW'(s2_col_q) == side_m1);

  assign mask_p = '{left_ok: (s2_col_q > AddrW'(1)), right_ok: 1'b1,
                    top_ok: top_ok, bot_ok: bot_ok};
  assign mask_s = '{left_ok: (s2_col_q != '0), right_ok: 1'b0,
                    top_ok: top_ok, bot_ok: bot_ok};

  gmf_vote u_vote_p (
    .left_i(win[0]), .center_i(win[1]), .right_i(win[2]), .mask_i(mask_p), .ill_o(ill_p)
  );
  gmf_vote u_vote_s (
    .left_i(win[1]), .center_i(win[2]), .right_i(win[2]), .mask_i(mask_s), .ill_o(ill_s)
  );

  assign res_p     = '{next_ill: ill_p, frame_end: 1'b0};
  assign res_s     = '{next_ill: ill_s, frame_end: (s2_row_q == side_q)};
  assign first_res = emit_p ? res_p : res_s;
  assign n_push    = {emit_p & emit_s, emit_p ^ emit_s};

  // output queue
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign next_ill_o  = fifo_q[head_q].next_ill;
  assign frame_end_o = fifo_q[head_q].frame_end;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[tail_q] <= first_res;
    end
    if (n_push == 2'd2) begin
      fifo_q[tail_q + 1'b1] <= res_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cfg_we) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_q + PtrW'(n_push);
      head_q  <= head_q + PtrW'(pop);
      count_q <= count_q + CntW'(n_push) - CntW'(pop);
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(gmf_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_flush_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q == side_q) |-> in_stall_o)
    else $error("input taken while draining last row");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SideW'(col_q) < side_q)
    else $error("column counter beyond grid side");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (row_q == '0 && col_q == '0 && count_q == '0 && !s1_v_q))
    else $error("side write did not restart the frame");

endmodule
